@@ design/periodic_radial_profile_binner_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the radial profile binner
// Immediate-implication and next-cycle checks; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_RADIAL_PROFILE_BINNER_CORE_MACROS_SVH
`define PERIODIC_RADIAL_PROFILE_BINNER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PRPB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("prpb check failed");
`define PRPB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("prpb check failed");
`else
`define PRPB_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)
`define PRPB_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

@@ design/prpb_pkg.sv @@
// ---------------------------------------------------------------------------
// prpb_pkg
// Shared types and constants of the radial profile binner.
// ---------------------------------------------------------------------------
package prpb_pkg;

  localparam int POS_W     = 30;
  localparam int CFG_W     = 30;
  localparam int BINC_W    = 7;
  localparam int HALOC_W   = 11;
  localparam int CNT_W     = 32;
  localparam int SQ_W      = 62;
  localparam int ROOT_W    = 31;
  localparam int DIV_BITS  = 7;
  localparam int PROD_W    = 37;
  localparam int STEP_W    = 5;
  localparam int IDX_EXT_W = 17;
  localparam int BIN_EXT_W = 9;
  localparam int AXES       = 3;
  localparam int SQRT_STEPS = 31;

  localparam logic [1:0] FUNC_LOAD     = 2'd0;
  localparam logic [1:0] FUNC_PARTICLE = 2'd1;
  localparam logic [1:0] FUNC_READ     = 2'd2;

  localparam logic [1:0] CFG_BOX   = 2'd0;
  localparam logic [1:0] CFG_WIDTH = 2'd1;
  localparam logic [1:0] CFG_BINS  = 2'd2;
  localparam logic [1:0] CFG_HALOS = 2'd3;

  localparam logic [CFG_W-1:0]   BOX_RESET   = 30'h3FFF_FFFF;
  localparam logic [CFG_W-1:0]   WIDTH_RESET = 30'd4096;
  localparam logic [BINC_W-1:0]  BINS_RESET  = 7'd10;
  localparam logic [HALOC_W-1:0] HALOS_RESET = 11'd0;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_RD, ST_RD_OUT, ST_PSTART, ST_CRD, ST_FOLD,
    ST_SQ, ST_SQI, ST_SQRT, ST_DIVI, ST_DIV, ST_CHK, ST_UPD, ST_NEXT
  } state_t;

  typedef struct packed {
    logic       clr_write;
    logic       latch_item;
    logic       load_write;
    logic       cnt_read;
    logic       out_load;
    logic       halo_start;
    logic       halo_next;
    logic       centre_read;
    logic       fold;
    logic [1:0] axis;
    logic       square;
    logic       first;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       upd_read;
    logic       upd_write;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       clr_last;
    logic       skip;
    logic       in_range;
    logic       halo_last;
    logic       out_free;
  } stat_t;

endpackage

@@ design/prpb_ctrl.sv @@
// ---------------------------------------------------------------------------
// prpb_ctrl
// Sequencer: clear pass, item dispatch and the per-halo particle steps.
// ---------------------------------------------------------------------------
module prpb_ctrl import prpb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (stat.clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (stat.func)
            FUNC_LOAD:     state_next = ST_LOAD;
            FUNC_PARTICLE: state_next = ST_PSTART;
            FUNC_READ:     state_next = ST_RD;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:   state_next = ST_IDLE;
      ST_RD:     state_next = ST_RD_OUT;
      ST_RD_OUT: if (stat.out_free) state_next = ST_IDLE;
      ST_PSTART: state_next = stat.skip ? ST_IDLE : ST_CRD;
      ST_CRD:    state_next = ST_FOLD;
      ST_FOLD:   state_next = ST_SQ;
      ST_SQ:     state_next = (step == STEP_W'(AXES - 1)) ? ST_SQI : ST_FOLD;
      ST_SQI:    state_next = ST_SQRT;
      ST_SQRT:   if (step == STEP_W'(SQRT_STEPS - 1)) state_next = ST_DIVI;
      ST_DIVI:   state_next = ST_DIV;
      ST_DIV:    if (step == STEP_W'(DIV_BITS - 1)) state_next = ST_CHK;
      ST_CHK:    state_next = stat.in_range ? ST_UPD : ST_NEXT;
      ST_UPD:    state_next = ST_NEXT;
      ST_NEXT:   state_next = stat.halo_last ? ST_IDLE : ST_CRD;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    step_next = step;
    in_ready  = 1'b0;
    unique case (state)
      ST_CLEAR:  cmd.clr_write = 1'b1;
      ST_IDLE: begin
        in_ready       = 1'b1;
        cmd.latch_item = in_valid;
      end
      ST_LOAD:   cmd.load_write = 1'b1;
      ST_RD:     cmd.cnt_read = 1'b1;
      ST_RD_OUT: cmd.out_load = stat.out_free;
      ST_PSTART: cmd.halo_start = !stat.skip;
      ST_CRD: begin
        cmd.centre_read = 1'b1;
        step_next       = '0;
      end
      ST_FOLD: begin
        cmd.fold = 1'b1;
        cmd.axis = step[1:0];
      end
      ST_SQ: begin
        cmd.square = 1'b1;
        cmd.first  = (step == '0);
        step_next  = (step == STEP_W'(AXES - 1)) ? '0 : step + 1'b1;
      end
      ST_SQI:    cmd.sqrt_init = 1'b1;
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = (step == STEP_W'(SQRT_STEPS - 1)) ? '0 : step + 1'b1;
      end
      ST_DIVI:   cmd.div_init = 1'b1;
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = (step == STEP_W'(DIV_BITS - 1)) ? '0 : step + 1'b1;
      end
      ST_CHK:    cmd.upd_read = stat.in_range;
      ST_UPD:    cmd.upd_write = 1'b1;
      ST_NEXT:   cmd.halo_next = !stat.halo_last;
      default:   cmd = '0;
    endcase
  end

endmodule

@@ design/prpb_dp.sv @@
// ---------------------------------------------------------------------------
// prpb_dp
// Datapath: config registers, centre and counter memories, periodic fold,
// squared distance, bit-serial square root and bin search, result register.
// ---------------------------------------------------------------------------
`include "periodic_radial_profile_binner_core_macros.svh"

module prpb_dp import prpb_pkg::*; #(
  parameter int MAX_HALOS = 1024,
  parameter int MAX_BINS  = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [1:0]          func,
  input  logic [9:0]          halo_index,
  input  logic [5:0]          bin_index,
  input  logic                species,
  input  logic [POS_W-1:0]    pos_x,
  input  logic [POS_W-1:0]    pos_y,
  input  logic [POS_W-1:0]    pos_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CNT_W-1:0]    bin_total,
  input  cmd_t                cmd,
  output stat_t               stat
);

  localparam int HALO_W    = (MAX_HALOS > 1) ? $clog2(MAX_HALOS) : 1;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int CA_W      = HALO_W + BIN_W;
  localparam int CNT_DEPTH = MAX_HALOS * (2 ** BIN_W);

  // configuration
  logic [CFG_W-1:0]   box_size, bin_width;
  logic [BINC_W-1:0]  bin_count;
  logic [HALOC_W-1:0] halo_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_size   <= BOX_RESET;
      bin_width  <= WIDTH_RESET;
      bin_count  <= BINS_RESET;
      halo_count <= HALOS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX:   box_size   <= cfg_data;
        CFG_WIDTH: bin_width  <= cfg_data;
        CFG_BINS:  bin_count  <= cfg_data[BINC_W-1:0];
        CFG_HALOS: halo_count <= cfg_data[HALOC_W-1:0];
      endcase
    end
  end

  logic [BIN_EXT_W-1:0] bc_ext, max_bins_c, nb_ext;
  logic [BINC_W-1:0]    nb;
  logic [IDX_EXT_W-1:0] hc_ext, max_halos_c, nh;

  assign bc_ext      = BIN_EXT_W'(bin_count);
  assign max_bins_c  = BIN_EXT_W'(MAX_BINS);
  assign nb_ext      = (bc_ext < max_bins_c) ? bc_ext : max_bins_c;
  assign nb          = nb_ext[BINC_W-1:0];
  assign hc_ext      = IDX_EXT_W'(halo_count);
  assign max_halos_c = IDX_EXT_W'(MAX_HALOS);
  assign nh          = (hc_ext < max_halos_c) ? hc_ext : max_halos_c;

  // item capture
  logic [IDX_EXT_W-1:0] hidx_ext;
  logic [BIN_EXT_W-1:0] bidx_ext;
  logic [HALO_W-1:0]    it_hidx;
  logic [BIN_W-1:0]     it_bidx;
  logic                 it_sp, it_rd_ok, it_load_ok;
  logic [POS_W-1:0]     it_px, it_py, it_pz;

  assign hidx_ext = IDX_EXT_W'(halo_index);
  assign bidx_ext = BIN_EXT_W'(bin_index);

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      it_hidx    <= hidx_ext[HALO_W-1:0];
      it_bidx    <= bidx_ext[BIN_W-1:0];
      it_sp      <= species;
      it_load_ok <= hidx_ext < max_halos_c;
      it_rd_ok   <= (hidx_ext < max_halos_c) && (bidx_ext < max_bins_c);
      it_px      <= pos_x;
      it_py      <= pos_y;
      it_pz      <= pos_z;
    end
  end

  // halo loop
  logic [HALO_W-1:0] j;

  always_ff @(posedge clk) begin
    if (cmd.halo_start) begin
      j <= '0;
    end else if (cmd.halo_next) begin
      j <= j + 1'b1;
    end
  end

  // centre memory, {x, y, z}
  logic [3*POS_W-1:0] centre_mem [MAX_HALOS];
  logic [3*POS_W-1:0] centre_q;

  always_ff @(posedge clk) begin
    if (cmd.load_write && it_load_ok) centre_mem[it_hidx] <= {it_px, it_py, it_pz};
    if (cmd.centre_read) centre_q <= centre_mem[j];
  end

  // periodic fold of one axis
  logic [POS_W-1:0]   p_sel, c_sel, abs_d;
  logic signed [32:0] b_s, d0, d1, d2, d_abs;

  always_comb begin
    unique case (cmd.axis)
      2'd0: begin
        p_sel = it_px;
        c_sel = centre_q[3*POS_W-1:2*POS_W];
      end
      2'd1: begin
        p_sel = it_py;
        c_sel = centre_q[2*POS_W-1:POS_W];
      end
      default: begin
        p_sel = it_pz;
        c_sel = centre_q[POS_W-1:0];
      end
    endcase
    b_s   = $signed({3'b000, box_size});
    d0    = $signed({3'b000, p_sel}) - $signed({3'b000, c_sel});
    d1    = ((d0 <<< 1) > b_s) ? d0 - b_s : d0;
    d2    = ((d1 <<< 1) < -b_s) ? d1 + b_s : d1;
    d_abs = d2[32] ? -d2 : d2;
  end

  always_ff @(posedge clk) begin
    if (cmd.fold) abs_d <= d_abs[POS_W-1:0];
  end

  // squared distance
  logic [2*POS_W-1:0] sq_prod;
  logic [SQ_W-1:0]    sum;

  assign sq_prod = abs_d * abs_d;

  always_ff @(posedge clk) begin
    if (cmd.square) sum <= (cmd.first ? '0 : sum) + SQ_W'(sq_prod);
  end

  // integer square root, two bits of radicand per step
  logic [SQ_W-1:0]   sq_op, sq_res, sq_one, sq_t;
  logic [ROOT_W-1:0] root;

  assign sq_t = sq_res + sq_one;
  assign root = sq_res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_op  <= sum;
      sq_res <= '0;
      sq_one <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.sqrt_step) begin
      if (sq_op >= sq_t) begin
        sq_op  <= sq_op - sq_t;
        sq_res <= (sq_res >> 1) + sq_one;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_one <= sq_one >> 2;
    end
  end

  // bin = floor(root / bin_width), one quotient bit per step
  logic [DIV_BITS-1:0]  div_q, div_bit, trial;
  logic [PROD_W-1:0]    div_prod, rng_prod;
  logic                 in_range;
  logic [BIN_EXT_W-1:0] q_ext;
  logic [BIN_W-1:0]     upd_bin;

  assign trial    = div_q | div_bit;
  assign div_prod = PROD_W'(trial) * PROD_W'(bin_width);
  assign rng_prod = PROD_W'(nb) * PROD_W'(bin_width);
  assign q_ext    = BIN_EXT_W'(div_q);
  assign upd_bin  = q_ext[BIN_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      div_q    <= '0;
      div_bit  <= DIV_BITS'(1) << (DIV_BITS - 1);
      in_range <= rng_prod > PROD_W'(root);
    end else if (cmd.div_step) begin
      if (div_prod <= PROD_W'(root)) div_q <= trial;
      div_bit <= div_bit >> 1;
    end
  end

  // counter memories
  logic [CNT_W-1:0] dark_mem [CNT_DEPTH];
  logic [CNT_W-1:0] neu_mem  [CNT_DEPTH];
  logic [CNT_W-1:0] dark_q, neu_q, old_cnt, cnt_wdata;
  logic [CA_W-1:0]  clr_addr, upd_addr, cnt_raddr, cnt_waddr;
  logic             cnt_re, we_dark, we_neu, clr_last;

  assign clr_last  = (clr_addr == CA_W'(CNT_DEPTH - 1));
  assign upd_addr  = {j, upd_bin};
  assign cnt_raddr = cmd.upd_read ? upd_addr : {it_hidx, it_bidx};
  assign cnt_re    = cmd.cnt_read | cmd.upd_read;
  assign cnt_waddr = cmd.clr_write ? clr_addr : upd_addr;
  assign old_cnt   = it_sp ? neu_q : dark_q;
  assign cnt_wdata = cmd.clr_write ? '0 : ((&old_cnt) ? old_cnt : old_cnt + 1'b1);
  assign we_dark   = cmd.clr_write | (cmd.upd_write & !it_sp);
  assign we_neu    = cmd.clr_write | (cmd.upd_write & it_sp);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_write && !clr_last) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we_dark) dark_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) dark_q <= dark_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (we_neu) neu_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) neu_q <= neu_mem[cnt_raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) bin_total <= it_rd_ok ? old_cnt : '0;
  end

  assign stat.func      = func;
  assign stat.clr_last  = clr_last;
  assign stat.skip      = (bin_width == '0) || (nb == '0) || (nh == '0);
  assign stat.in_range  = in_range;
  assign stat.halo_last = (IDX_EXT_W'(j) == nh - 1'b1);
  assign stat.out_free  = !out_valid || out_ready;

  `PRPB_ASSERT_IMP(a_out_free, clk, rst, cmd.out_load, !out_valid || out_ready)
  `PRPB_ASSERT_IMP(a_upd_range, clk, rst, cmd.upd_read, in_range && (BIN_EXT_W'(div_q) < nb_ext))
  `PRPB_ASSERT_IMP(a_halo_bound, clk, rst, cmd.centre_read, IDX_EXT_W'(j) < nh)
  `PRPB_ASSERT_NXT(a_rmw_pair, clk, rst, cmd.upd_read, cmd.upd_write)

endmodule

@@ design/periodic_radial_profile_binner_core.sv @@
// ---------------------------------------------------------------------------
// periodic_radial_profile_binner_core
// Per-halo radial histograms of particles in a periodic box.
//
//   channel  signals                                        handshake
//   cfg      cfg_we cfg_index cfg_data                      write enable
//   in       func halo_index bin_index species pos_x/y/z    in_valid/in_ready
//   out      bin_total                                      out_valid/out_ready
//
// A read waits until the result register is free.
// Particle: per active halo a centre read, a fold and square for each axis,
//   the 31-step square root, the 7-step bin search and a count if in range.
// After reset the counter memories are cleared, MAX_HALOS * 2^ceil(log2
//   MAX_BINS) entries (65536 by default); no item is taken until then.
// A waiting result does not block loads or particles.
// ---------------------------------------------------------------------------
module periodic_radial_profile_binner_core import prpb_pkg::*; #(
  parameter int MAX_HALOS = 1024,
  parameter int MAX_BINS  = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       func,
  input  logic [9:0]       halo_index,
  input  logic [5:0]       bin_index,
  input  logic             species,
  input  logic [POS_W-1:0] pos_x,
  input  logic [POS_W-1:0] pos_y,
  input  logic [POS_W-1:0] pos_z,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CNT_W-1:0] bin_total
);

  cmd_t  cmd;
  stat_t stat;

  prpb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  prpb_dp #(
    .MAX_HALOS (MAX_HALOS),
    .MAX_BINS  (MAX_BINS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .func       (func),
    .halo_index (halo_index),
    .bin_index  (bin_index),
    .species    (species),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bin_total  (bin_total),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule
